// ----- rtl/core/vtc_pkg.sv -----
// Shared constants, types and single-precision helper functions for the vertex transform.
package vtc_pkg;

  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned CFG_IDX_W = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS01 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS23 = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS01 = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS23 = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS01 = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS23 = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS01 = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS23 = 4'd7;

  // Reset values: identity matrix
  localparam logic [63:0] RST_ROW0_COLS01 = 64'h0000_0000_3F80_0000;
  localparam logic [63:0] RST_ROW0_COLS23 = 64'h0000_0000_0000_0000;
  localparam logic [63:0] RST_ROW1_COLS01 = 64'h3F80_0000_0000_0000;
  localparam logic [63:0] RST_ROW1_COLS23 = 64'h0000_0000_0000_0000;
  localparam logic [63:0] RST_ROW2_COLS01 = 64'h0000_0000_0000_0000;
  localparam logic [63:0] RST_ROW2_COLS23 = 64'h0000_0000_3F80_0000;
  localparam logic [63:0] RST_ROW3_COLS01 = 64'h0000_0000_0000_0000;
  localparam logic [63:0] RST_ROW3_COLS23 = 64'h3F80_0000_0000_0000;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

  typedef struct packed {
    logic nan;
    logic inf;
    logic zero;
  } fp_flags_t;

  // Classify an IEEE single bit pattern
  function automatic fp_flags_t classify(input logic [31:0] v);
    fp_flags_t f;
    f.nan  = (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    f.inf  = (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
    f.zero = (v[30:0] == 31'd0);
    return f;
  endfunction

  // Exponent with subnormals taken at the minimum normal exponent
  function automatic logic [7:0] eff_exp(input logic [31:0] v);
    return (v[30:23] == 8'd0) ? 8'd1 : v[30:23];
  endfunction

  // Significand with the hidden bit
  function automatic logic [23:0] full_mant(input logic [31:0] v);
    return {v[30:23] != 8'd0, v[22:0]};
  endfunction

  // Leading zero count over 48 bits; 48 when the word is zero
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  // Round to nearest even and pack. m[26] is the leading one, m[2] the guard bit,
  // m[1:0] sticky; e is the biased exponent of that leading one.
  function automatic logic [31:0] round_pack(input logic sign, input logic signed [10:0] e,
                                             input logic [26:0] m);
    logic [26:0] ms;
    logic [26:0] mask;
    logic [10:0] dsh;
    logic [4:0]  sh;
    logic        inc;
    logic [30:0] body;
    logic [31:0] res;
    ms   = m;
    mask = '0;
    dsh  = '0;
    sh   = '0;
    body = '0;
    inc  = 1'b0;
    if (e >= 11'sd255) begin
      res = {sign, 8'hFF, 23'd0};
    end else begin
      if (e >= 11'sd1) begin
        body = {e[7:0], 23'd0};
      end else begin
        // denormalize with sticky
        dsh  = 11'(11'sd1 - e);
        sh   = (dsh > 11'd27) ? 5'd27 : dsh[4:0];
        mask = (27'd1 << sh) - 27'd1;
        ms   = (m >> sh) | {26'd0, |(m & mask)};
      end
      inc  = ms[2] & (ms[3] | ms[1] | ms[0]);
      body = body + {8'd0, ms[25:3]} + {30'd0, inc};
      res  = {sign, body};
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/vtc_stream_if.sv -----
// Valid/ready stream interfaces for the point input and the projected result.
interface vtc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] in_x;
  logic [31:0] in_y;
  logic [31:0] in_z;
  modport source (output valid, output in_x, output in_y, output in_z, input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

interface vtc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  logic        w_was_zero;
  modport source (output valid, output out_x, output out_y, output out_z, output w_was_zero,
                  input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z, input w_was_zero,
                  output ready);
endinterface

// ----- rtl/core/vertex_transform_coord.sv -----
// Vertex transform: each point (x, y, z) is taken as the row vector (x, y, z, 1), multiplied
// by the 4x4 single-precision matrix in the configuration registers, and divided by its
// homogeneous w through a rounded reciprocal 1/w; every step rounds to nearest even with
// subnormals kept, and NaN results come out as 0x7FC00000. When w is +0 or -0 the result is
// all zeros with w_was_zero set. The pipeline is 26 register stages deep and takes one point
// per clock: 3 for the twelve products, 9 for the three chained adds per column, 10 for the
// reciprocal (normalize, seven radix-2 divider stages of four quotient bits each, round),
// 3 for the final products and 1 output register. The whole pipeline holds while a finished
// result is not taken. Write the matrix only while no point is in flight.
module vertex_transform_coord (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [vtc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                  cfg_data,
  vtc_in_if.sink                       point,
  vtc_out_if.source                    result
);

  localparam int LAT      = 26;
  localparam int COL_DLY  = 10;
  localparam int DIV_STG  = 7;

  typedef struct packed {
    logic               sign;
    logic               nan;
    logic               inf;
    logic               zero;
    logic signed [10:0] e;
    logic [23:0]        mn;
    logic [24:0]        rem;
    logic [27:0]        q;
  } div_stage_t;

  typedef struct packed {
    logic        sign;
    logic        nan;
    logic        inf;
    logic        zero;
    logic [7:0]  ew;
    logic [23:0] mant;
    logic [5:0]  lz;
  } rcp_in_t;

  logic [63:0] cfg [vtc_pkg::NUM_REGS];
  logic        adv;
  logic [LAT-1:0] vld;
  logic [31:0] coord [3];
  logic [31:0] prod  [4][3];
  logic [31:0] p2d   [4][3];
  logic [31:0] sa    [4];
  logic [31:0] sb    [4];
  logic [31:0] sc    [4];
  logic [31:0] m3    [4];
  logic [31:0] cold  [COL_DLY][3];
  logic [31:0] fin   [3];
  rcp_in_t     r1;
  rcp_in_t     r1_next;
  div_stage_t  dv [DIV_STG+1];
  div_stage_t  dv0_next;
  logic [31:0] rcp;
  logic        rcp_wz;
  logic [2:0]  wzd;
  logic [26:0] rm27;
  logic signed [10:0] re;
  logic        rst_k;
  logic [31:0] ox, oy, oz;
  logic        owz;

  // Four quotient bits of restoring division
  function automatic div_stage_t div_step4(input div_stage_t s);
    div_stage_t t;
    t = s;
    for (int i = 0; i < 4; i++) begin
      if (t.rem >= {1'b0, t.mn}) begin
        t.rem = t.rem - {1'b0, t.mn};
        t.q   = {t.q[26:0], 1'b1};
      end else begin
        t.q   = {t.q[26:0], 1'b0};
      end
      t.rem = {t.rem[23:0], 1'b0};
    end
    return t;
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg[0] <= vtc_pkg::RST_ROW0_COLS01;
      cfg[1] <= vtc_pkg::RST_ROW0_COLS23;
      cfg[2] <= vtc_pkg::RST_ROW1_COLS01;
      cfg[3] <= vtc_pkg::RST_ROW1_COLS23;
      cfg[4] <= vtc_pkg::RST_ROW2_COLS01;
      cfg[5] <= vtc_pkg::RST_ROW2_COLS23;
      cfg[6] <= vtc_pkg::RST_ROW3_COLS01;
      cfg[7] <= vtc_pkg::RST_ROW3_COLS23;
    end else if (cfg_we) begin
      case (cfg_index)
        vtc_pkg::REG_ROW0_COLS01: cfg[0] <= cfg_data;
        vtc_pkg::REG_ROW0_COLS23: cfg[1] <= cfg_data;
        vtc_pkg::REG_ROW1_COLS01: cfg[2] <= cfg_data;
        vtc_pkg::REG_ROW1_COLS23: cfg[3] <= cfg_data;
        vtc_pkg::REG_ROW2_COLS01: cfg[4] <= cfg_data;
        vtc_pkg::REG_ROW2_COLS23: cfg[5] <= cfg_data;
        vtc_pkg::REG_ROW3_COLS01: cfg[6] <= cfg_data;
        vtc_pkg::REG_ROW3_COLS23: cfg[7] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance everything together unless the output holds an untaken result
  assign adv         = !vld[LAT-1] || result.ready;
  assign point.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], point.valid};
    end
  end

  assign coord[0] = point.in_x;
  assign coord[1] = point.in_y;
  assign coord[2] = point.in_z;

  // Column sums: ((m0c*x + m1c*y) + m2c*z) + m3c
  for (genvar c = 0; c < 4; c++) begin : g_col
    assign m3[c] = (c % 2 == 1) ? cfg[6 + c / 2][63:32] : cfg[6 + c / 2][31:0];
    for (genvar r = 0; r < 3; r++) begin : g_row
      vtc_fmul u_mul (
        .clk (clk),
        .en  (adv),
        .a   ((c % 2 == 1) ? cfg[2 * r + c / 2][63:32] : cfg[2 * r + c / 2][31:0]),
        .b   (coord[r]),
        .y   (prod[c][r])
      );
    end
    vtc_fadd u_add01 (.clk(clk), .en(adv), .a(prod[c][0]), .b(prod[c][1]), .y(sa[c]));
    vtc_fadd u_add2  (.clk(clk), .en(adv), .a(sa[c]),      .b(p2d[c][2]),  .y(sb[c]));
    vtc_fadd u_add3  (.clk(clk), .en(adv), .a(sb[c]),      .b(m3[c]),      .y(sc[c]));
  end

  // Hold the z product for the second add
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        p2d[c][0] <= prod[c][2];
        p2d[c][1] <= p2d[c][0];
        p2d[c][2] <= p2d[c][1];
      end
    end
  end

  // Delay the x, y, z column sums across the reciprocal
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        cold[0][c] <= sc[c];
      end
      for (int k = 1; k < COL_DLY; k++) begin
        cold[k] <= cold[k-1];
      end
    end
  end

  // Reciprocal front end: classify w and count leading zeros of its significand
  always_comb begin
    vtc_pkg::fp_flags_t fw;
    fw = vtc_pkg::classify(sc[3]);
    r1_next.sign = sc[3][31];
    r1_next.nan  = fw.nan;
    r1_next.inf  = fw.inf;
    r1_next.zero = fw.zero;
    r1_next.ew   = vtc_pkg::eff_exp(sc[3]);
    r1_next.mant = vtc_pkg::full_mant(sc[3]);
    r1_next.lz   = vtc_pkg::lzc48({vtc_pkg::full_mant(sc[3]), 24'd0});
  end

  // Normalize the divisor and seed the remainder with 1.0
  always_comb begin
    dv0_next.sign = r1.sign;
    dv0_next.nan  = r1.nan;
    dv0_next.inf  = r1.inf;
    dv0_next.zero = r1.zero;
    dv0_next.e    = 11'sd254 - $signed({3'b0, r1.ew}) + $signed({5'b0, r1.lz});
    dv0_next.mn   = r1.mant << r1.lz;
    dv0_next.rem  = 25'h080_0000;
    dv0_next.q    = '0;
  end

  // Place the quotient's leading one and round
  always_comb begin
    rst_k = dv[DIV_STG].rem != 25'd0;
    if (dv[DIV_STG].q[27]) begin
      rm27 = {dv[DIV_STG].q[27:2], |dv[DIV_STG].q[1:0] | rst_k};
      re   = dv[DIV_STG].e;
    end else begin
      rm27 = {dv[DIV_STG].q[26:1], dv[DIV_STG].q[0] | rst_k};
      re   = dv[DIV_STG].e - 11'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r1    <= r1_next;
      dv[0] <= dv0_next;
      for (int k = 1; k <= DIV_STG; k++) begin
        dv[k] <= div_step4(dv[k-1]);
      end
      rcp_wz <= dv[DIV_STG].zero;
      if (dv[DIV_STG].nan) begin
        rcp <= vtc_pkg::CANON_NAN;
      end else if (dv[DIV_STG].inf || dv[DIV_STG].zero) begin
        rcp <= {dv[DIV_STG].sign, 31'd0};
      end else begin
        rcp <= vtc_pkg::round_pack(dv[DIV_STG].sign, re, rm27);
      end
    end
  end

  // Scale by the reciprocal
  for (genvar c = 0; c < 3; c++) begin : g_scale
    vtc_fmul u_scale (.clk(clk), .en(adv), .a(cold[COL_DLY-1][c]), .b(rcp), .y(fin[c]));
  end

  // Output register: zero the result when w was zero
  always_ff @(posedge clk) begin
    if (adv) begin
      wzd <= {wzd[1:0], rcp_wz};
      owz <= wzd[2];
      ox  <= wzd[2] ? 32'd0 : fin[0];
      oy  <= wzd[2] ? 32'd0 : fin[1];
      oz  <= wzd[2] ? 32'd0 : fin[2];
    end
  end

  assign result.valid      = vld[LAT-1];
  assign result.out_x      = ox;
  assign result.out_y      = oy;
  assign result.out_z      = oz;
  assign result.w_was_zero = owz;

  // A held pipeline keeps its occupancy
  a_hold_occupancy: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline occupancy changed while held");

  // Zero w yields an all-zero point
  a_zero_w: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.w_was_zero) |->
      (result.out_x == 32'd0 && result.out_y == 32'd0 && result.out_z == 32'd0))
    else $error("w_was_zero with nonzero coordinates");

  // NaN results on out_x are canonical
  a_canon_nan: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.out_x[30:23] == 8'hFF && result.out_x[22:0] != 23'd0) |->
      (result.out_x == vtc_pkg::CANON_NAN))
    else $error("non-canonical NaN on out_x");

endmodule

// ----- rtl/core/vtc_fmul.sv -----
// Three-stage single-precision multiplier: product, leading zero count, normalize and round.
module vtc_fmul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  typedef struct packed {
    logic               sign;
    logic               nan;
    logic               inf;
    logic               zero;
    logic signed [10:0] e;
    logic [47:0]        prod;
  } mul_stage_t;

  vtc_pkg::fp_flags_t fa, fb;
  mul_stage_t s1_next, s1, s2;
  logic [5:0]  lz;
  logic [47:0] pn;
  logic signed [10:0] e3;
  logic [26:0] m27;

  // Stage 1: classify and multiply significands
  always_comb begin
    fa = vtc_pkg::classify(a);
    fb = vtc_pkg::classify(b);
    s1_next.sign = a[31] ^ b[31];
    s1_next.nan  = fa.nan | fb.nan | (fa.inf & fb.zero) | (fb.inf & fa.zero);
    s1_next.inf  = fa.inf | fb.inf;
    s1_next.zero = fa.zero | fb.zero;
    s1_next.e    = $signed({3'b0, vtc_pkg::eff_exp(a)}) + $signed({3'b0, vtc_pkg::eff_exp(b)})
                   - 11'sd126;
    s1_next.prod = 48'(vtc_pkg::full_mant(a)) * 48'(vtc_pkg::full_mant(b));
  end

  // Normalize the product
  always_comb begin
    pn  = s2.prod << lz;
    e3  = s2.e - $signed({5'b0, lz});
    m27 = {pn[47:22], |pn[21:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s1_next;
      s2 <= s1;
      lz <= vtc_pkg::lzc48(s1.prod);
      if (s2.nan) begin
        y <= vtc_pkg::CANON_NAN;
      end else if (s2.inf) begin
        y <= {s2.sign, 8'hFF, 23'd0};
      end else if (s2.zero) begin
        y <= {s2.sign, 31'd0};
      end else begin
        y <= vtc_pkg::round_pack(s2.sign, e3, m27);
      end
    end
  end

endmodule

// ----- rtl/core/vtc_fadd.sv -----
// Three-stage single-precision adder: align and add, leading zero count, normalize and round.
module vtc_fadd (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  typedef struct packed {
    logic               sign;
    logic               nan;
    logic               inf;
    logic               inf_sign;
    logic               zero_sign;
    logic signed [10:0] e;
    logic [27:0]        sum;
  } add_stage_t;

  vtc_pkg::fp_flags_t fa, fb;
  add_stage_t s1_next, s1, s2;
  logic        swap;
  logic [31:0] big, lit;
  logic [7:0]  eb, el, d;
  logic [4:0]  sh;
  logic [26:0] mbig, mlit, mask, al;
  logic [5:0]  lz;
  logic [27:0] pn;
  logic signed [10:0] e3;
  logic [26:0] m27;

  // Stage 1: order by magnitude, align the smaller operand, add or subtract
  always_comb begin
    fa   = vtc_pkg::classify(a);
    fb   = vtc_pkg::classify(b);
    swap = b[30:0] > a[30:0];
    big  = swap ? b : a;
    lit  = swap ? a : b;
    eb   = vtc_pkg::eff_exp(big);
    el   = vtc_pkg::eff_exp(lit);
    d    = eb - el;
    sh   = (d > 8'd27) ? 5'd27 : d[4:0];
    mbig = {vtc_pkg::full_mant(big), 3'b000};
    mlit = {vtc_pkg::full_mant(lit), 3'b000};
    mask = (27'd1 << sh) - 27'd1;
    al   = (mlit >> sh) | {26'd0, |(mlit & mask)};
    s1_next.sign      = big[31];
    s1_next.nan       = fa.nan | fb.nan | (fa.inf & fb.inf & (a[31] != b[31]));
    s1_next.inf       = fa.inf | fb.inf;
    s1_next.inf_sign  = fa.inf ? a[31] : b[31];
    s1_next.zero_sign = a[31] & b[31];
    s1_next.e         = $signed({3'b0, eb});
    s1_next.sum       = (big[31] ^ lit[31]) ? ({1'b0, mbig} - {1'b0, al})
                                            : ({1'b0, mbig} + {1'b0, al});
  end

  // Normalize the sum
  always_comb begin
    pn  = s2.sum << lz;
    e3  = s2.e + 11'sd1 - $signed({5'b0, lz});
    m27 = {pn[27:2], |pn[1:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s1_next;
      s2 <= s1;
      lz <= vtc_pkg::lzc48({s1.sum, 20'd0});
      if (s2.nan) begin
        y <= vtc_pkg::CANON_NAN;
      end else if (s2.inf) begin
        y <= {s2.inf_sign, 8'hFF, 23'd0};
      end else if (s2.sum == 28'd0) begin
        y <= {s2.zero_sign, 31'd0};
      end else begin
        y <= vtc_pkg::round_pack(s2.sign, e3, m27);
      end
    end
  end

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the vertex transform: random stall stimulus and a float predictor.
module tb_top;

  localparam int IDLE_PCT   = 33;
  localparam int DRAIN_WAIT = 40;
  localparam int STALL_MAX  = 3000;
  localparam int RAND_ITEMS = 128;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } point_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        w_zero;
  } proj_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [vtc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [63:0] cfg_data;

  vtc_in_if  point_if ();
  vtc_out_if result_if ();

  vertex_transform_coord dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .point     (point_if),
    .result    (result_if)
  );

  logic [63:0] matrix_regs [vtc_pkg::NUM_REGS];
  point_t      pending_points [$];
  proj_t       expected_projs [$];
  logic        point_taken;
  logic        steady;
  int          errors;
  int          stall_cycles;

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Widen a single-precision pattern to a real, exactly
  function automatic real sp_to_real(input logic [31:0] b);
    logic [10:0] de;
    logic [23:0] mm;
    if (b[30:23] == 8'hFF) begin
      if (b[22:0] != 23'd0) return $bitstoreal(64'h7FF8_0000_0000_0000);
      return $bitstoreal({b[31], 11'h7FF, 52'd0});
    end
    if (b[30:0] == 31'd0) return $bitstoreal({b[31], 63'd0});
    if (b[30:23] == 8'd0) begin
      de = 11'd897;
      mm = {1'b0, b[22:0]};
      while (!mm[23]) begin
        mm = mm << 1;
        de = de - 11'd1;
      end
      return $bitstoreal({b[31], de, mm[22:0], 29'd0});
    end
    return $bitstoreal({b[31], 11'(b[30:23] + 11'd896), b[22:0], 29'd0});
  endfunction

  // Round a real to single precision, nearest even, subnormals kept, NaN canonical
  function automatic logic [31:0] real_to_sp(input real r);
    logic [63:0] d;
    logic [63:0] sig;
    logic [63:0] kept;
    logic [63:0] rem;
    logic [63:0] half;
    int          be;
    int          sh;
    d = $realtobits(r);
    if (d[62:52] == 11'h7FF) begin
      if (d[51:0] != 52'd0) return vtc_pkg::CANON_NAN;
      return {d[63], 8'hFF, 23'd0};
    end
    if (d[62:52] == 11'd0) return {d[63], 31'd0};
    sig = {11'd0, 1'b1, d[51:0]};
    be  = int'(d[62:52]) - 1023 + 127;
    sh  = (be >= 1) ? 29 : 29 + 1 - be;
    if (sh > 63) sh = 63;
    kept = sig >> sh;
    rem  = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
    if (be < 1) return {d[63], kept[30:0]};
    if (kept[24]) begin
      kept = kept >> 1;
      be   = be + 1;
    end
    if (be >= 255) return {d[63], 8'hFF, 23'd0};
    return {d[63], 8'(be), kept[22:0]};
  endfunction

  function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
    return real_to_sp(sp_to_real(a) * sp_to_real(b));
  endfunction

  function automatic logic [31:0] sp_add(input logic [31:0] a, input logic [31:0] b);
    return real_to_sp(sp_to_real(a) + sp_to_real(b));
  endfunction

  function automatic logic [31:0] mat_entry(input int row, input int col);
    logic [63:0] r;
    r = matrix_regs[row * 2 + col / 2];
    return (col % 2) ? r[63:32] : r[31:0];
  endfunction

  // ((m0c*x + m1c*y) + m2c*z) + m3c, each step rounded
  function automatic logic [31:0] column_dot(input int col, input point_t p);
    logic [31:0] s;
    s = sp_add(sp_mul(mat_entry(0, col), p.x), sp_mul(mat_entry(1, col), p.y));
    s = sp_add(s, sp_mul(mat_entry(2, col), p.z));
    return sp_add(s, mat_entry(3, col));
  endfunction

  function automatic proj_t project_point(input point_t p);
    proj_t       o;
    logic [31:0] w;
    logic [31:0] recip;
    w = column_dot(3, p);
    o = '0;
    if (w[30:0] == 31'd0) begin
      o.w_zero = 1'b1;
    end else begin
      recip = real_to_sp(1.0 / sp_to_real(w));
      o.x = sp_mul(column_dot(0, p), recip);
      o.y = sp_mul(column_dot(1, p), recip);
      o.z = sp_mul(column_dot(2, p), recip);
    end
    return o;
  endfunction

  // Moderate-magnitude float with random sign and mantissa
  function automatic logic [31:0] mild_float();
    return {1'($urandom), 8'($urandom_range(117, 137)), 23'($urandom)};
  endfunction

  function automatic logic [31:0] special_float();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'h0000_0000;
      1: v = 32'h8000_0000;
      2: v = 32'h7F80_0000;
      3: v = 32'hFF80_0000;
      4: v = 32'h7FC0_0000;
      5: v = 32'h0000_0001;
      6: v = 32'h7F7F_FFFF;
      7: v = 32'h3F80_0000;
      8: v = {1'($urandom), 8'd0, 23'($urandom)};
      default: v = {1'($urandom), 8'($urandom_range(230, 254)), 23'($urandom)};
    endcase
    return v;
  endfunction

  function automatic logic [31:0] any_float();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return mild_float();
    if (pick < 85) return 32'($urandom);
    return special_float();
  endfunction

  // Write all registers back to back, then one ignored index above them
  task automatic load_matrix(input logic [63:0] vals [vtc_pkg::NUM_REGS]);
    for (int i = 0; i < vtc_pkg::NUM_REGS; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= vtc_pkg::REG_ROW0_COLS01 + vtc_pkg::CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      matrix_regs[i] = vals[i];
    end
    @(negedge clk);
    cfg_index <= vtc_pkg::REG_ROW3_COLS23 + vtc_pkg::CFG_IDX_W'($urandom_range(1, 8));
    cfg_data  <= {$urandom, $urandom};
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    pending_points.insert(pending_points.size(), p);
  endtask

  // Hold until every point is taken and every result is back, then let the pipe settle
  task automatic drain();
    while (pending_points.size() != 0 || point_if.valid || expected_projs.size() != 0)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic random_points(input bit hit_unit_x);
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (hit_unit_x && $urandom_range(0, 9) == 0)
        queue_point(32'h3F80_0000, any_float(), any_float());
      else
        queue_point(any_float(), any_float(), any_float());
    end
  endtask

  // Stimulus
  initial begin
    logic [63:0] m [vtc_pkg::NUM_REGS];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    point_if.valid = 1'b0;
    point_if.in_x = '0;
    point_if.in_y = '0;
    point_if.in_z = '0;
    result_if.ready = 1'b0;
    steady = 1'b0;
    errors = 0;
    matrix_regs[0] = vtc_pkg::RST_ROW0_COLS01;
    matrix_regs[1] = vtc_pkg::RST_ROW0_COLS23;
    matrix_regs[2] = vtc_pkg::RST_ROW1_COLS01;
    matrix_regs[3] = vtc_pkg::RST_ROW1_COLS23;
    matrix_regs[4] = vtc_pkg::RST_ROW2_COLS01;
    matrix_regs[5] = vtc_pkg::RST_ROW2_COLS23;
    matrix_regs[6] = vtc_pkg::RST_ROW3_COLS01;
    matrix_regs[7] = vtc_pkg::RST_ROW3_COLS23;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Identity after reset: extremes of the inputs, then random points
    queue_point(32'h0000_0000, 32'h8000_0000, 32'h0000_0001);
    queue_point(32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h807F_FFFF);
    queue_point(32'h7F80_0000, 32'hFF80_0000, 32'hFFFF_FFFF);
    queue_point(32'h3F80_0000, 32'hBF80_0000, 32'h4049_0FDB);
    random_points(1'b0);
    drain();

    // w = x - 1: zero w, NaN w, infinite w, tiny w
    m = '{64'h3F80_0000_0000_0000, 64'h3F80_0000_3F80_0000, 64'h3F80_0000_4000_0000,
          64'h0000_0000_BF80_0000, 64'hC000_0000_0000_0000, 64'h0000_0000_3F00_0000,
          64'h3F80_0000_3F80_0000, 64'hBF80_0000_0000_0000};
    load_matrix(m);
    queue_point(32'h3F80_0000, 32'h4000_0000, 32'h4040_0000);
    queue_point(32'h3F80_0000, 32'h7F80_0000, 32'hFFFF_FFFF);
    queue_point(32'h7FC0_0001, 32'h3F80_0000, 32'h3F80_0000);
    queue_point(32'h7F80_0000, 32'h3F80_0000, 32'h3F80_0000);
    queue_point(32'hFF80_0000, 32'h0000_0000, 32'h0000_0000);
    queue_point(32'h3F80_0001, 32'h7F7F_FFFF, 32'h0000_0001);
    queue_point(32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
    queue_point(32'h3F7F_FFFF, 32'h8000_0001, 32'h3F80_0000);
    random_points(1'b1);
    drain();

    // All-zero matrix: w is zero unless an input is infinite or NaN
    m = '{default: 64'd0};
    load_matrix(m);
    queue_point(32'h3F80_0000, 32'h7F80_0000, 32'h7FC0_0000);
    for (int i = 0; i < 40; i++) queue_point(any_float(), any_float(), any_float());
    drain();

    // All ones: every entry NaN
    m = '{default: 64'hFFFF_FFFF_FFFF_FFFF};
    load_matrix(m);
    for (int i = 0; i < 40; i++) queue_point(any_float(), any_float(), any_float());
    drain();

    // Moderate random matrices, one run with no idling at all
    for (int ph = 0; ph < 3; ph++) begin
      for (int i = 0; i < vtc_pkg::NUM_REGS; i++) m[i] = {mild_float(), mild_float()};
      load_matrix(m);
      steady = (ph == 1);
      random_points(1'b0);
      drain();
    end
    steady = 1'b0;

    // Raw random register bits
    for (int i = 0; i < vtc_pkg::NUM_REGS; i++) m[i] = {$urandom, $urandom};
    load_matrix(m);
    random_points(1'b0);
    drain();

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Driver: advance on acceptance, idle at random
  always @(negedge clk) begin
    if (!rst && !(point_if.valid && !point_taken)) begin
      if (pending_points.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
        point_t p;
        p = pending_points.pop_front();
        point_if.valid <= 1'b1;
        point_if.in_x  <= p.x;
        point_if.in_y  <= p.y;
        point_if.in_z  <= p.z;
      end else begin
        point_if.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    if (!rst) result_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Record accepted points and check accepted results
  always @(posedge clk) begin
    proj_t got;
    proj_t want;
    point_t p;
    point_taken <= !rst && point_if.valid && point_if.ready;
    if (!rst && point_if.valid && point_if.ready) begin
      p.x = point_if.in_x;
      p.y = point_if.in_y;
      p.z = point_if.in_z;
      expected_projs.insert(expected_projs.size(), project_point(p));
    end
    if (!rst && result_if.valid && result_if.ready) begin
      got.x      = result_if.out_x;
      got.y      = result_if.out_y;
      got.z      = result_if.out_z;
      got.w_zero = result_if.w_was_zero;
      if (expected_projs.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction %h", $time, got);
      end else begin
        want = expected_projs.pop_front();
        if (got.x !== want.x) begin
          errors++;
          $display("%0t: out_x expected %h actual %h", $time, want.x, got.x);
        end
        if (got.y !== want.y) begin
          errors++;
          $display("%0t: out_y expected %h actual %h", $time, want.y, got.y);
        end
        if (got.z !== want.z) begin
          errors++;
          $display("%0t: out_z expected %h actual %h", $time, want.z, got.z);
        end
        if (got.w_zero !== want.w_zero) begin
          errors++;
          $display("%0t: w_was_zero expected %b actual %b", $time, want.w_zero, got.w_zero);
        end
      end
    end
  end

  // Watchdog: count cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (point_if.valid && point_if.ready) || (result_if.valid && result_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule
